// ===== design/prime_field_arithmetic_unit_macros.svh =====
// Assertion macros for the prime field arithmetic unit.
// Used by prime_field_arithmetic_unit.sv; expects clk and rst_n in scope.
`ifndef PRIME_FIELD_ARITHMETIC_UNIT_MACROS_SVH
`define PRIME_FIELD_ARITHMETIC_UNIT_MACROS_SVH

// Property that must hold at every edge out of reset.
`define PFAU_CHK(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Antecedent at one edge implies consequent at the next.
`define PFAU_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/pfau_pkg.sv =====
// Package for the prime field arithmetic unit: modulus, opcodes, sequencer types.
// No dependencies.
package pfau_pkg;

    localparam int OperandWidth = 30;
    localparam logic [OperandWidth-1:0] FIELD_P = 30'd1000000007;
    localparam logic [OperandWidth-1:0] FIELD_P_MINUS_2 = 30'd1000000005;

    typedef enum logic [2:0] {
        OP_ADD = 3'd0,
        OP_SUB = 3'd1,
        OP_MUL = 3'd2,
        OP_DIV = 3'd3,
        OP_POW = 3'd4,
        OP_INV = 3'd5
    } op_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CALC,
        S_LOOP,
        S_MUL,
        S_OUT
    } state_t;

    // What the running serial multiply feeds when it finishes
    typedef enum logic [1:0] {
        J_SINGLE,
        J_ACC,
        J_SQR,
        J_DIVFIN
    } job_t;

endpackage

// ===== design/prime_field_arithmetic_unit.sv =====
// Prime field arithmetic unit, modulus 1000000007, bit-serial modular multiplier.
// Depends on pfau_pkg.sv and prime_field_arithmetic_unit_macros.svh.
//
// Usage:
//   Request words enter on s_tvalid/s_tready/s_tdata; one result word leaves on
//   m_tvalid/m_tready/m_tdata per request. The unit works on one request at a
//   time: s_tready is high only while idle.
//   Operands are reduced mod p on entry (one conditional subtract).
//   Work done per opcode after the accepting edge:
//     add, subtract, unused opcodes: result formed directly, no multiply
//     multiply: one serial multiply, one bit of the multiplier per cycle
//     power: square-and-multiply over the exponent bits, LSB first, one serial
//            product per squaring and per multiply
//     inverse: exponent p-2 (30 bits, 15 ones)
//     divide: inverse plus one more multiply
//   Throughput is set by the single shared serial multiplier: each modular
//   product is formed one doubling and conditional add per cycle.
//   Reset clears the sequencer to idle; no request or result is pending.
//   When the receiver stalls, the result word holds on m_tdata with m_tvalid
//   high and no new request is taken until it is accepted.
`include "prime_field_arithmetic_unit_macros.svh"

module prime_field_arithmetic_unit
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // req_type[2:0], operand_a[32:3], operand_b[62:33], zero pad
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // result[29:0], zero pad
);
    import pfau_pkg::*;

    localparam int W = OperandWidth;

    state_t         state_reg, state_next;
    job_t           job_reg, job_next;
    logic [2:0]     op_reg, op_next;
    logic [W-1:0]   a_reg, a_next;
    logic [W-1:0]   b_reg, b_next;
    logic [W-1:0]   base_reg, base_next;
    logic [W-1:0]   exp_reg, exp_next;
    logic [W-1:0]   acc_reg, acc_next;
    logic [W-1:0]   res_reg, res_next;
    logic           div_reg, div_next;
    logic [W-1:0]   mx_reg, mx_next;    // multiplicand
    logic [W-1:0]   my_reg, my_next;    // multiplier, shifted out MSB first
    logic [W-1:0]   mp_reg, mp_next;    // partial product
    logic [4:0]     mcnt_reg, mcnt_next;

    // Input reduction
    logic [W-1:0]   in_a, in_b, red_a, red_b;
    assign in_a  = s_tdata[32:3];
    assign in_b  = s_tdata[62:33];
    assign red_a = (in_a >= FIELD_P) ? in_a - FIELD_P : in_a;
    assign red_b = (in_b >= FIELD_P) ? in_b - FIELD_P : in_b;

    // One multiplier step: p = 2p + (bit ? x : 0) mod P
    logic [W:0]     dbl, sum, add_s, sub_s;
    logic [W-1:0]   dbl_r, step_p, add_r;
    assign dbl    = {mp_reg, 1'b0};
    assign dbl_r  = (dbl >= {1'b0, FIELD_P}) ? W'(dbl - {1'b0, FIELD_P}) : dbl[W-1:0];
    assign sum    = {1'b0, dbl_r} + (my_reg[W-1] ? {1'b0, mx_reg} : '0);
    assign step_p = (sum >= {1'b0, FIELD_P}) ? W'(sum - {1'b0, FIELD_P}) : sum[W-1:0];

    // Add and subtract
    assign add_s = {1'b0, a_reg} + {1'b0, b_reg};
    assign add_r = (add_s >= {1'b0, FIELD_P}) ? W'(add_s - {1'b0, FIELD_P}) : add_s[W-1:0];
    assign sub_s = {1'b0, a_reg} + {1'b0, FIELD_P} - {1'b0, b_reg};

    always_comb
    begin
        state_next = state_reg;
        job_next   = job_reg;
        op_next    = op_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        base_next  = base_reg;
        exp_next   = exp_reg;
        acc_next   = acc_reg;
        res_next   = res_reg;
        div_next   = div_reg;
        mx_next    = mx_reg;
        my_next    = my_reg;
        mp_next    = mp_reg;
        mcnt_next  = mcnt_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    op_next    = s_tdata[2:0];
                    a_next     = red_a;
                    b_next     = red_b;
                    state_next = S_CALC;
                end
            end
            S_CALC:
            begin
                acc_next   = W'(1);
                div_next   = 1'b0;
                mp_next    = '0;
                mcnt_next  = '0;
                state_next = S_LOOP;
                case (op_reg)
                    OP_ADD:
                    begin
                        res_next   = add_r;
                        state_next = S_OUT;
                    end
                    OP_SUB:
                    begin
                        res_next   = (a_reg >= b_reg) ? a_reg - b_reg : sub_s[W-1:0];
                        state_next = S_OUT;
                    end
                    OP_MUL:
                    begin
                        mx_next    = a_reg;
                        my_next    = b_reg;
                        job_next   = J_SINGLE;
                        state_next = S_MUL;
                    end
                    OP_DIV:
                    begin
                        base_next = b_reg;
                        exp_next  = FIELD_P_MINUS_2;
                        div_next  = 1'b1;
                    end
                    OP_POW:
                    begin
                        base_next = a_reg;
                        exp_next  = b_reg;
                    end
                    OP_INV:
                    begin
                        base_next = a_reg;
                        exp_next  = FIELD_P_MINUS_2;
                    end
                    default:
                    begin
                        res_next   = '0;
                        state_next = S_OUT;
                    end
                endcase
            end
            S_LOOP:
            begin
                mp_next    = '0;
                mcnt_next  = '0;
                state_next = S_MUL;
                if (exp_reg == '0)
                begin
                    if (div_reg)
                    begin
                        mx_next  = a_reg;
                        my_next  = acc_reg;
                        job_next = J_DIVFIN;
                    end
                    else
                    begin
                        res_next   = acc_reg;
                        state_next = S_OUT;
                    end
                end
                else if (exp_reg[0])
                begin
                    mx_next  = base_reg;
                    my_next  = acc_reg;
                    job_next = J_ACC;
                end
                else
                begin
                    mx_next  = base_reg;
                    my_next  = base_reg;
                    job_next = J_SQR;
                end
            end
            S_MUL:
            begin
                mp_next   = step_p;
                my_next   = {my_reg[W-2:0], 1'b0};
                mcnt_next = mcnt_reg + 5'd1;
                if (mcnt_reg == 5'(W - 1))
                begin
                    unique case (job_reg)
                        J_SINGLE, J_DIVFIN:
                        begin
                            res_next   = step_p;
                            state_next = S_OUT;
                        end
                        J_ACC:
                        begin
                            // chain straight into the squaring
                            acc_next  = step_p;
                            mx_next   = base_reg;
                            my_next   = base_reg;
                            mp_next   = '0;
                            mcnt_next = '0;
                            job_next  = J_SQR;
                        end
                        J_SQR:
                        begin
                            base_next  = step_p;
                            exp_next   = {1'b0, exp_reg[W-1:1]};
                            state_next = S_LOOP;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_OUT:
            begin
                if (m_tready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            job_reg   <= J_SINGLE;
            mcnt_reg  <= '0;
            div_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            job_reg   <= job_next;
            mcnt_reg  <= mcnt_next;
            div_reg   <= div_next;
        end
    end

    // Payload registers, no reset
    always_ff @(posedge clk)
    begin
        op_reg   <= op_next;
        a_reg    <= a_next;
        b_reg    <= b_next;
        base_reg <= base_next;
        exp_reg  <= exp_next;
        acc_reg  <= acc_next;
        res_reg  <= res_next;
        mx_reg   <= mx_next;
        my_reg   <= my_next;
        mp_reg   <= mp_next;
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = (state_reg == S_OUT);
    assign m_tdata  = {2'b00, res_reg};

    `PFAU_CHK(a_result_canonical, !m_tvalid || (res_reg < FIELD_P), "result not below p")
    `PFAU_CHK(a_partial_canonical, (state_reg != S_MUL) || (mp_reg < FIELD_P), "partial >= p")
    `PFAU_CHK(a_one_side_busy, !(s_tready && m_tvalid), "request and result open together")
    `PFAU_NEXT(a_back_to_idle, m_tvalid && m_tready, s_tready, "no return to idle")

endmodule
